>>> design/homogeneous_triangle_clipper_macros.svh
// Assertion macros shared by the clipper RTL
`ifndef HOMOGENEOUS_TRIANGLE_CLIPPER_MACROS_SVH
`define HOMOGENEOUS_TRIANGLE_CLIPPER_MACROS_SVH

// same-cycle implication
`define HTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clipper assertion failed");

// next-cycle implication
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clipper assertion failed");

`endif

>>> design/htc_pkg.sv
package htc_pkg;

   localparam logic [2:0] PLANE_LEFT   = 3'd0;
   localparam logic [2:0] PLANE_RIGHT  = 3'd1;
   localparam logic [2:0] PLANE_BOTTOM = 3'd2;
   localparam logic [2:0] PLANE_TOP    = 3'd3;
   localparam logic [2:0] PLANE_NEAR   = 3'd4;
   localparam logic [2:0] PLANE_FAR    = 3'd5;

   localparam int COORD_W = 32;
   localparam int ATTR_W  = 16;
   localparam int DIST_W  = 34;
   localparam int NUM_W   = 34;
   localparam int DEN_W   = 35;
   localparam int T_W     = 17;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [DIST_W-1:0] plane_dist(
      input logic [2:0] plane,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z,
      input logic signed [COORD_W-1:0] w
   );
      logic signed [DIST_W-1:0] xe, ye, ze, we, r;
      xe = DIST_W'(x);
      ye = DIST_W'(y);
      ze = DIST_W'(z);
      we = DIST_W'(w);
      case (plane)
         PLANE_LEFT:   r = we + xe;
         PLANE_RIGHT:  r = we - xe;
         PLANE_BOTTOM: r = we + ye;
         PLANE_TOP:    r = we - ye;
         PLANE_NEAR:   r = we + ze;
         PLANE_FAR:    r = we - ze;
         default:      r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> design/homogeneous_triangle_clipper.sv
// Homogeneous triangle clipper.
// req_ channel: one vertex per request; three requests make a triangle.
// rsp_ channel: the clipped polygon, one vertex per request, tlast on the
// final one; a fully clipped triangle gives one request with tuser set.
// Each vertex is written to the RAMs as it is accepted. After the third the
// block runs six plane passes over the polygon held in two RAMs
// (coordinates and attributes), ping-ponging between two banks in each. Per
// edge it reads both ends and computes their plane distances; an edge that
// crosses the plane runs the divider and then interpolates one component
// per multiply. Output vertices are read from the RAMs one at a time, each
// held in the output register until the receiver takes it.
// req_tready is high only while loading; it stays low until the last output
// request has been taken. When rsp_tready is low the output register holds.
// Reset is synchronous: it empties the block and returns to loading; RAM
// contents are not cleared, only entries written for the current triangle
// are read.
module homogeneous_triangle_clipper #(
   parameter int MAX_VERTS   = 9,
   parameter int PLANE_COUNT = 6
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vert_x, vert_y, vert_z, vert_w, attr_red, attr_green, attr_blue
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // clip_x, clip_y, clip_z, clip_w, out_red, out_green, out_blue
   output logic [175:0] rsp_tdata,
   // poly_empty
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

`include "homogeneous_triangle_clipper_macros.svh"

   localparam int DEPTH = 2 * MAX_VERTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAX_VERTS);
   localparam int CW    = $clog2(MAX_VERTS + 1);
   localparam int CRD_W = 4 * htc_pkg::COORD_W;
   localparam int ATR_W = 3 * htc_pkg::ATTR_W;

   typedef enum logic [3:0] {
      S_LOAD, S_PASS, S_RDA, S_RDB, S_LATB, S_DIST, S_DEC, S_DIV,
      S_MUL, S_ACC, S_WI, S_WB, S_NEXT, S_ORD, S_OLAT, S_OHOLD
   } state_type;

   state_type state_ff;
   logic [1:0]  loaded_ff;
   logic [2:0]  plane_ff;
   logic        bank_ff;
   logic [CW-1:0] n_ff, m_ff;
   logic [IW-1:0] i_ff;
   logic [2:0]  k_ff;
   logic [CRD_W-1:0] va_crd_ff, vb_crd_ff, vi_crd_ff;
   logic [ATR_W-1:0] va_atr_ff, vb_atr_ff, vi_atr_ff;
   logic signed [htc_pkg::DIST_W-1:0] da_ff, db_ff;
   logic [htc_pkg::T_W-1:0] t_ff;
   logic signed [50:0] prod_ff;
   logic        rsp_tvalid_ff, rsp_tlast_ff, rsp_tuser_ff;
   logic [175:0] rsp_tdata_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CRD_W-1:0] wr_crd, rd_crd;
   logic [ATR_W-1:0] wr_atr, rd_atr;
   logic [IW-1:0] rd_idx, j_idx;
   logic          edge_last, room, req_acc;
   logic          div_start;
   htc_pkg::div_stat_type div_stat;
   logic [htc_pkg::T_W-1:0] div_quo;
   logic [htc_pkg::NUM_W-1:0] div_num;
   logic [htc_pkg::DEN_W-1:0] div_den;
   logic signed [htc_pkg::DIST_W:0] dd;
   logic signed [32:0] a_sel, b_sel, diff;
   logic signed [50:0] prod_rnd;
   logic signed [34:0] res;

   assign req_acc   = req_tvalid && req_tready;
   assign edge_last = (CW'(i_ff) + CW'(1)) == n_ff;
   assign j_idx     = edge_last ? '0 : IW'(i_ff + IW'(1));
   assign room      = m_ff < CW'(MAX_VERTS);

   always_comb begin
      case (state_ff)
         S_RDB:   rd_idx = j_idx;
         default: rd_idx = i_ff;
      endcase
      rd_addr = bank_ff ? AW'(MAX_VERTS) + AW'(rd_idx) : AW'(rd_idx);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(loaded_ff);
      wr_crd  = req_tdata[CRD_W-1:0];
      wr_atr  = req_tdata[CRD_W +: ATR_W];
      if (state_ff == S_LOAD) begin
         wr_en = req_acc;
      end else begin
         wr_addr = !bank_ff ? AW'(MAX_VERTS) + AW'(m_ff[IW-1:0]) : AW'(m_ff[IW-1:0]);
         if (state_ff == S_WI) begin
            wr_en  = room;
            wr_crd = vi_crd_ff;
            wr_atr = vi_atr_ff;
         end else if (state_ff == S_WB) begin
            wr_en  = room;
            wr_crd = vb_crd_ff;
            wr_atr = vb_atr_ff;
         end
      end
   end

   htc_ram #(.WIDTH(CRD_W), .DEPTH(DEPTH)) u_crd_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_crd),
      .rd_addr(rd_addr), .rd_data(rd_crd)
   );

   htc_ram #(.WIDTH(ATR_W), .DEPTH(DEPTH)) u_atr_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_atr),
      .rd_addr(rd_addr), .rd_data(rd_atr)
   );

   // intersection parameter
   assign dd        = (htc_pkg::DIST_W+1)'(da_ff) - (htc_pkg::DIST_W+1)'(db_ff);
   assign div_num   = da_ff[htc_pkg::DIST_W-1] ? htc_pkg::NUM_W'(-da_ff)
                                               : htc_pkg::NUM_W'(da_ff);
   assign div_den   = dd[htc_pkg::DIST_W] ? htc_pkg::DEN_W'(-dd) : htc_pkg::DEN_W'(dd);
   assign div_start = (state_ff == S_DEC) && (da_ff[htc_pkg::DIST_W-1]
                      != db_ff[htc_pkg::DIST_W-1]);

   htc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .stat(div_stat), .quo(div_quo)
   );

   // one component per multiply
   always_comb begin
      if (k_ff < 3'd4) begin
         a_sel = 33'(signed'(va_crd_ff[k_ff[1:0]*htc_pkg::COORD_W +: htc_pkg::COORD_W]));
         b_sel = 33'(signed'(vb_crd_ff[k_ff[1:0]*htc_pkg::COORD_W +: htc_pkg::COORD_W]));
      end else begin
         a_sel = signed'({17'b0, va_atr_ff[2'(k_ff - 3'd4)*htc_pkg::ATTR_W +: htc_pkg::ATTR_W]});
         b_sel = signed'({17'b0, vb_atr_ff[2'(k_ff - 3'd4)*htc_pkg::ATTR_W +: htc_pkg::ATTR_W]});
      end
      diff     = b_sel - a_sel;
      prod_rnd = prod_ff + 51'sd32768;
      res      = 35'(a_sel) + prod_rnd[50:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         loaded_ff     <= '0;
         plane_ff      <= '0;
         bank_ff       <= 1'b0;
         n_ff          <= '0;
         m_ff          <= '0;
         i_ff          <= '0;
         k_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
         rsp_tuser_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (loaded_ff == 2'd2) begin
                     loaded_ff <= '0;
                     plane_ff  <= '0;
                     bank_ff   <= 1'b0;
                     n_ff      <= CW'(3);
                     state_ff  <= S_PASS;
                  end else begin
                     loaded_ff <= loaded_ff + 2'd1;
                  end
               end
            end
            S_PASS: begin
               i_ff <= '0;
               m_ff <= '0;
               if (plane_ff == 3'(PLANE_COUNT)) begin
                  if (n_ff == '0) begin
                     rsp_tdata_ff  <= '0;
                     rsp_tuser_ff  <= 1'b1;
                     rsp_tlast_ff  <= 1'b1;
                     rsp_tvalid_ff <= 1'b1;
                     state_ff      <= S_OHOLD;
                  end else begin
                     state_ff <= S_ORD;
                  end
               end else if (n_ff == '0) begin
                  plane_ff <= plane_ff + 3'd1;
                  bank_ff  <= !bank_ff;
               end else begin
                  state_ff <= S_RDA;
               end
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               va_crd_ff <= rd_crd;
               va_atr_ff <= rd_atr;
               state_ff  <= S_LATB;
            end
            S_LATB: begin
               vb_crd_ff <= rd_crd;
               vb_atr_ff <= rd_atr;
               state_ff  <= S_DIST;
            end
            S_DIST: begin
               da_ff <= htc_pkg::plane_dist(plane_ff, va_crd_ff[31:0], va_crd_ff[63:32],
                                            va_crd_ff[95:64], va_crd_ff[127:96]);
               db_ff <= htc_pkg::plane_dist(plane_ff, vb_crd_ff[31:0], vb_crd_ff[63:32],
                                            vb_crd_ff[95:64], vb_crd_ff[127:96]);
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (!da_ff[htc_pkg::DIST_W-1] && !db_ff[htc_pkg::DIST_W-1]) begin
                  state_ff <= S_WB;
               end else if (div_start) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  t_ff     <= div_quo;
                  k_ff     <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= diff * signed'({1'b0, t_ff});
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (k_ff < 3'd4) begin
                  vi_crd_ff[k_ff[1:0]*htc_pkg::COORD_W +: htc_pkg::COORD_W] <= res[31:0];
               end else begin
                  vi_atr_ff[2'(k_ff - 3'd4)*htc_pkg::ATTR_W +: htc_pkg::ATTR_W] <= res[15:0];
               end
               if (k_ff == 3'd6) begin
                  state_ff <= S_WI;
               end else begin
                  k_ff     <= k_ff + 3'd1;
                  state_ff <= S_MUL;
               end
            end
            S_WI: begin
               if (room) m_ff <= m_ff + CW'(1);
               state_ff <= da_ff[htc_pkg::DIST_W-1] ? S_WB : S_NEXT;
            end
            S_WB: begin
               if (room) m_ff <= m_ff + CW'(1);
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (edge_last) begin
                  n_ff     <= m_ff;
                  plane_ff <= plane_ff + 3'd1;
                  bank_ff  <= !bank_ff;
                  state_ff <= S_PASS;
               end else begin
                  i_ff     <= IW'(i_ff + IW'(1));
                  state_ff <= S_RDA;
               end
            end
            S_ORD: state_ff <= S_OLAT;
            S_OLAT: begin
               rsp_tdata_ff  <= {rd_atr, rd_crd};
               rsp_tuser_ff  <= 1'b0;
               rsp_tlast_ff  <= edge_last;
               rsp_tvalid_ff <= 1'b1;
               state_ff      <= S_OHOLD;
            end
            S_OHOLD: begin
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  if (rsp_tlast_ff) begin
                     state_ff <= S_LOAD;
                  end else begin
                     i_ff     <= IW'(i_ff + IW'(1));
                     state_ff <= S_ORD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_tready = state_ff == S_LOAD;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `HTC_ASSERT_IMPL(a_no_overlap, clock, reset, req_tready, !rsp_tvalid)
   `HTC_ASSERT_IMPL(a_div_in_wait, clock, reset, div_stat.done, state_ff == S_DIV)
   `HTC_ASSERT_IMPL(a_wr_room, clock, reset, wr_en && (state_ff != S_LOAD),
                    m_ff < CW'(MAX_VERTS))
   `HTC_ASSERT_NEXT(a_empty_last, clock, reset, state_ff == S_PASS && rsp_tuser_ff == 1'b0
                    && plane_ff == 3'(PLANE_COUNT) && n_ff == '0, rsp_tlast && rsp_tuser)

endmodule

>>> design/htc_ram.sv
module htc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/htc_div.sv
// restoring divider, one quotient bit per cycle
// quotient = ({num,16'b0} + den/2) / den, quotient below 2^17
module htc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [htc_pkg::NUM_W-1:0]   num,
   input  logic [htc_pkg::DEN_W-1:0]   den,
   output htc_pkg::div_stat_type       stat,
   output logic [htc_pkg::T_W-1:0]     quo
);

   localparam int DVD_W = htc_pkg::NUM_W + 17;

   logic [DVD_W-1:0]            dvd;
   logic [htc_pkg::DEN_W-1:0]   rem_ff;
   logic [htc_pkg::DEN_W-1:0]   den_ff;
   logic [htc_pkg::T_W-1:0]     sh_ff;
   logic [4:0]                  cnt_ff;
   logic                        busy_ff, done_ff;
   logic [htc_pkg::DEN_W:0]     trial;
   logic                        fits;

   assign dvd   = {1'b0, num, 16'b0} + DVD_W'(den >> 1);
   assign trial = {rem_ff, sh_ff[htc_pkg::T_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(htc_pkg::T_W);
            rem_ff  <= htc_pkg::DEN_W'(dvd[DVD_W-1:htc_pkg::T_W]);
            sh_ff   <= dvd[htc_pkg::T_W-1:0];
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= fits ? htc_pkg::DEN_W'(trial - {1'b0, den_ff})
                           : htc_pkg::DEN_W'(trial);
            sh_ff  <= {sh_ff[htc_pkg::T_W-2:0], fits};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = sh_ff;

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] x, y, z, w;
      logic [15:0] r, g, b;
   } vertex_type;

   typedef struct {
      vertex_type v;
      logic empty;
      logic last;
   } clip_result_type;

   localparam int MAX_VERTS = 9;
   localparam int N_PLANES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [175:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   homogeneous_triangle_clipper DUT (.*);

   always #2 clock = ~clock;

   vertex_type pending_verts[$];
   clip_result_type expected_verts[$];
   vertex_type tri_buf[3];
   int tri_fill = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_send = 1'b0;
   bit req_taken = 1'b0;

   function automatic logic signed [33:0] dist_to(int p, vertex_type v);
      logic signed [33:0] x, y, z, w;
      x = 34'(v.x);
      y = 34'(v.y);
      z = 34'(v.z);
      w = 34'(v.w);
      case (p)
         htc_pkg::PLANE_LEFT:   return w + x;
         htc_pkg::PLANE_RIGHT:  return w - x;
         htc_pkg::PLANE_BOTTOM: return w + y;
         htc_pkg::PLANE_TOP:    return w - y;
         htc_pkg::PLANE_NEAR:   return w + z;
         default:               return w - z;
      endcase
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      longint p;
      p = (b - a) * t + 32768;
      return a + (p >>> 16);
   endfunction

   function automatic vertex_type crossing(vertex_type a, vertex_type b, longint t);
      vertex_type c;
      c.x = 32'(blend(a.x, b.x, t));
      c.y = 32'(blend(a.y, b.y, t));
      c.z = 32'(blend(a.z, b.z, t));
      c.w = 32'(blend(a.w, b.w, t));
      c.r = 16'(blend(a.r, b.r, t));
      c.g = 16'(blend(a.g, b.g, t));
      c.b = 16'(blend(a.b, b.b, t));
      return c;
   endfunction

   task automatic clip_triangle();
      vertex_type poly[$];
      vertex_type nxt[$];
      vertex_type a, b;
      longint da, db, num, den, t;
      clip_result_type res;
      poly = '{tri_buf[0], tri_buf[1], tri_buf[2]};
      for (int p = 0; p < N_PLANES; p++) begin
         nxt = {};
         for (int i = 0; i < poly.size(); i++) begin
            a = poly[i];
            b = poly[(i + 1) % poly.size()];
            da = 64'(dist_to(p, a));
            db = 64'(dist_to(p, b));
            if (da >= 0 && db >= 0) begin
               if (nxt.size() < MAX_VERTS) nxt = {nxt, b};
            end else if (da >= 0 || db >= 0) begin
               num = da < 0 ? -da : da;
               den = (da - db) < 0 ? db - da : da - db;
               t = ((num << 16) + den / 2) / den;
               if (nxt.size() < MAX_VERTS) nxt = {nxt, crossing(a, b, t)};
               if (da < 0 && nxt.size() < MAX_VERTS) nxt = {nxt, b};
            end
         end
         poly = nxt;
      end
      if (poly.size() == 0) begin
         res.v = '{0, 0, 0, 0, 0, 0, 0};
         res.empty = 1'b1;
         res.last = 1'b1;
         expected_verts = {expected_verts, res};
      end else begin
         foreach (poly[k]) begin
            res.v = poly[k];
            res.empty = 1'b0;
            res.last = (k == poly.size() - 1);
            expected_verts = {expected_verts, res};
         end
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            if (pending_verts.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pack(pending_verts.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid && pending_verts.size() > 0 && !hold_send &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pack(pending_verts.pop_front());
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [175:0] pack(vertex_type v);
      return {v.b, v.g, v.r, v.w, v.z, v.y, v.x};
   endfunction

   always @(posedge clock) begin
      vertex_type v;
      clip_result_type e;
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            v.x = req_tdata[31:0];
            v.y = req_tdata[63:32];
            v.z = req_tdata[95:64];
            v.w = req_tdata[127:96];
            v.r = req_tdata[143:128];
            v.g = req_tdata[159:144];
            v.b = req_tdata[175:160];
            tri_buf[tri_fill] = v;
            tri_fill = tri_fill + 1;
            if (tri_fill == 3) begin
               tri_fill = 0;
               clip_triangle();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verts.size() == 0) begin
               $display("%0t: unexpected vertex %h tuser %b tlast %b", $time,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               e = expected_verts.pop_front();
               if (rsp_tdata !== pack(e.v) || rsp_tuser !== e.empty ||
                   rsp_tlast !== e.last) begin
                  $display("%0t: expected %h user %b last %b, got %h user %b last %b",
                           $time, pack(e.v), e.empty, e.last, rsp_tdata, rsp_tuser,
                           rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 262143)) - 131072;
         default: return $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      int mode;
      mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
      v.x = rand_coord(mode);
      v.y = rand_coord(mode);
      v.z = rand_coord(mode);
      v.w = mode == 0 ? 32'($urandom) : 32'($signed($urandom_range(0, 196608)) - 16384);
      v.r = 16'($urandom);
      v.g = 16'($urandom);
      v.b = 16'($urandom);
      return v;
   endfunction

   function automatic vertex_type mk(int x, int y, int z, int w, int r, int g, int b);
      vertex_type v;
      v.x = x; v.y = y; v.z = z; v.w = w;
      v.r = 16'(r); v.g = 16'(g); v.b = 16'(b);
      return v;
   endfunction

   task automatic queue_vert(vertex_type v);
      pending_verts = {pending_verts, v};
   endtask

   task automatic drain();
      while (pending_verts.size() > 0 || req_tvalid || expected_verts.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   localparam int ONE = 65536;

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // inside, straddling, fully outside, near and far plane crossing, extremes, zero w, negative w
      queue_vert(mk(0, 0, 0, ONE, 0, 0, 0));
      queue_vert(mk(ONE/2, 0, 0, ONE, 16'hffff, 16'hffff, 16'hffff));
      queue_vert(mk(0, ONE/2, 0, ONE, 16'h1234, 16'h8000, 16'h00ff));
      queue_vert(mk(-3*ONE, -3*ONE, 0, ONE, 0, 16'hffff, 0));
      queue_vert(mk(3*ONE, -3*ONE, 0, ONE, 16'hffff, 0, 0));
      queue_vert(mk(0, 3*ONE, 0, ONE, 0, 0, 16'hffff));
      queue_vert(mk(5*ONE, 5*ONE, 0, ONE, 1, 2, 3));
      queue_vert(mk(6*ONE, 5*ONE, 0, ONE, 4, 5, 6));
      queue_vert(mk(5*ONE, 6*ONE, 0, ONE, 7, 8, 9));
      queue_vert(mk(0, 0, -2*ONE, ONE, 0, 0, 0));
      queue_vert(mk(0, 0, 2*ONE, ONE, 16'hffff, 0, 16'hffff));
      queue_vert(mk(ONE/4, 0, 0, ONE, 16'h0f0f, 16'hf0f0, 16'h5555));
      queue_vert(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                    16'hffff, 16'hffff, 16'hffff));
      queue_vert(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    0, 0, 0));
      queue_vert(mk(32'hffffffff, 0, 32'h80000000, 32'h7fffffff,
                    16'haaaa, 16'h5555, 16'haaaa));
      queue_vert(mk(0, 0, 0, 0, 1, 1, 1));
      queue_vert(mk(0, 0, 0, 0, 2, 2, 2));
      queue_vert(mk(0, 0, 0, 0, 3, 3, 3));
      queue_vert(mk(0, 0, 0, -ONE, 0, 0, 0));
      queue_vert(mk(0, 0, 0, ONE, 0, 0, 0));
      queue_vert(mk(ONE, ONE, ONE, ONE, 9, 9, 9));
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 33) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 33) : 0;
         for (int i = 0; i < 120; i++) queue_vert(rand_vertex());
         if (ph == 1) begin
            while (pending_verts.size() > 60) @(posedge clock);
            while (req_tvalid || tri_fill != 0) @(posedge clock);
            hold_send = 1'b1;
            while (expected_verts.size() > 0) @(posedge clock);
            hold_send = 1'b0;
         end
         drain();
      end
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("tb: errors");
      $finish;
   end

endmodule
